>>> design/lol_pkg.sv
// Shared types, codes and sizes for the LRU order list.
package lol_pkg;

    localparam int NUM_ENTRIES = 256;
    localparam int SLOT_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int IDX_W       = 8;
    localparam int CMD_W       = 2;
    localparam int STAT_W      = 2;
    localparam int IN_DATA_W   = ((CMD_W + IDX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((STAT_W + IDX_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUMP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_LISTED = 2'd2;
    localparam logic [STAT_W-1:0] ST_LISTED     = 2'd3;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [IDX_W-1:0]  t_idx;

    // A pointer: valid bit plus slot number; valid clear means null.
    typedef struct packed {
        logic  valid;
        t_slot slot;
    } t_link;

    typedef struct packed {
        logic  we;
        t_slot waddr;
        t_link wdata;
        t_slot raddr;
    } t_ram_req;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        t_idx             entry_index;
    } t_cmd;

    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        t_idx              popped_index;
    } t_result;

endpackage

>>> design/lol_link_ram.sv
// One link memory of the list: one write port, one read port, registered read data.
module lol_link_ram (
    input  logic              i_clk,
    input  lol_pkg::t_ram_req i_req,
    output lol_pkg::t_link    o_rdata
);
    import lol_pkg::*;

    t_link r_mem [NUM_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

>>> design/lol_ctrl.sv
// Command sequencer: head pointers, membership bits and read-modify-write of the link memories.
module lol_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  lol_pkg::t_cmd     i_cmd,
    output logic              o_idle,
    input  logic              i_res_ready,
    output lol_pkg::t_result  o_res,
    output lol_pkg::t_ram_req o_newer_req,
    input  lol_pkg::t_link    i_newer_rdata,
    output lol_pkg::t_ram_req o_older_req,
    input  lol_pkg::t_link    i_older_rdata
);
    import lol_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DET   = 3'd2;
    localparam logic [2:0] S_ATT1  = 3'd3;
    localparam logic [2:0] S_ATT2  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [CMD_W-1:0]       r_cmd, n_cmd;
    t_idx                   r_entry, n_entry;
    t_slot                  r_x, n_x;
    t_link                  r_newest, n_newest;
    t_link                  r_oldest, n_oldest;
    logic [NUM_ENTRIES-1:0] r_listed, n_listed;
    logic [STAT_W-1:0]      r_status, n_status;
    t_idx                   r_popped, n_popped;

    t_slot w_target;
    logic  w_in_range;

    // Pop works on the oldest slot, every other command on the given slot.
    assign w_target   = (r_cmd == CMD_POP) ? r_oldest.slot : t_slot'(r_entry);
    assign w_in_range = int'(r_entry) < NUM_ENTRIES;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_entry  = r_entry;
        n_x      = r_x;
        n_newest = r_newest;
        n_oldest = r_oldest;
        n_listed = r_listed;
        n_status = r_status;
        n_popped = r_popped;

        o_newer_req       = '0;
        o_older_req       = '0;
        o_newer_req.raddr = w_target;
        o_older_req.raddr = w_target;

        o_res              = '0;
        o_res.status       = r_status;
        o_res.popped_index = r_popped;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd.command;
                    n_entry = i_cmd.entry_index;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // Both links of the target are read here; data arrives in S_DET.
                n_x      = w_target;
                n_status = ST_OK;
                n_popped = '0;
                n_state  = S_DONE;
                unique case (r_cmd)
                    CMD_POP: begin
                        if (!r_oldest.valid) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_state = S_DET;
                        end
                    end
                    CMD_ADD: begin
                        if (!w_in_range) begin
                            n_status = ST_NOT_LISTED;
                        end else if (r_listed[w_target]) begin
                            n_status = ST_LISTED;
                        end else begin
                            n_state = S_ATT1;
                        end
                    end
                    CMD_BUMP: begin
                        if (!w_in_range || !r_listed[w_target]) begin
                            n_status = ST_NOT_LISTED;
                        end else if (!(r_newest.valid && r_newest.slot == w_target)) begin
                            n_state = S_DET;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!w_in_range || !r_listed[w_target]) begin
                            n_status = ST_NOT_LISTED;
                        end else begin
                            n_state = S_DET;
                        end
                    end
                    default: n_status = ST_NOT_LISTED;
                endcase
            end
            S_DET: begin
                // Unlink: the newer neighbor takes our older link and vice versa.
                o_older_req.we    = i_newer_rdata.valid;
                o_older_req.waddr = i_newer_rdata.slot;
                o_older_req.wdata = i_older_rdata;
                o_newer_req.we    = i_older_rdata.valid;
                o_newer_req.waddr = i_older_rdata.slot;
                o_newer_req.wdata = i_newer_rdata;
                if (!i_newer_rdata.valid) begin
                    n_newest = i_older_rdata;
                end
                if (!i_older_rdata.valid) begin
                    n_oldest = i_newer_rdata;
                end
                n_listed[r_x] = 1'b0;
                if (r_cmd == CMD_BUMP) begin
                    n_state = S_ATT1;
                end else begin
                    if (r_cmd == CMD_POP) begin
                        n_popped = t_idx'(r_x);
                    end
                    n_state = S_DONE;
                end
            end
            S_ATT1: begin
                o_older_req.we    = 1'b1;
                o_older_req.waddr = r_x;
                o_older_req.wdata = r_newest;
                o_newer_req.we    = 1'b1;
                o_newer_req.waddr = r_x;
                o_newer_req.wdata = '0;
                if (r_newest.valid) begin
                    n_state = S_ATT2;
                end else begin
                    n_oldest      = '{valid: 1'b1, slot: r_x};
                    n_newest      = '{valid: 1'b1, slot: r_x};
                    n_listed[r_x] = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_ATT2: begin
                o_newer_req.we    = 1'b1;
                o_newer_req.waddr = r_newest.slot;
                o_newer_req.wdata = '{valid: 1'b1, slot: r_x};
                n_newest          = '{valid: 1'b1, slot: r_x};
                n_listed[r_x]     = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                o_res.valid = i_res_ready;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_newest <= '0;
            r_oldest <= '0;
            r_listed <= '0;
        end else begin
            r_state  <= n_state;
            r_newest <= n_newest;
            r_oldest <= n_oldest;
            r_listed <= n_listed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_entry  <= n_entry;
        r_x      <= n_x;
        r_status <= n_status;
        r_popped <= n_popped;
    end

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cmd_valid) |=> r_state == S_CHECK)
        else $error("accepted command did not enter the check step");

    a_heads_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_newest.valid == r_oldest.valid)
        else $error("newest and oldest heads disagree on an empty list");

    a_newest_listed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_newest.valid |-> r_listed[r_newest.slot])
        else $error("newest head points at an unlisted slot");

    a_oldest_listed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oldest.valid |-> r_listed[r_oldest.slot])
        else $error("oldest head points at an unlisted slot");

endmodule

>>> design/lru_order_list.sv
// Top level of the LRU order list: stream ports, output register, sequencer and link memories.
//
//  Port group   Direction  Payload (tdata, lowest bit first)
//  s (i_s_*)    in         command[1:0], entry_index[9:2], zero fill to 16 bits
//  m (o_m_*)    out        status[1:0], popped_index[9:2], zero fill to 16 bits
//
// One command is in flight at a time. An error or a bump of the newest slot goes from the check
// step straight to done; pop and remove pass the unlink step, add one or two attach steps and
// bump the unlink step and both attach steps, as each link memory has a single write port.
// Reset is synchronous and clears the heads and membership bits at once.
// The result sits in an output register, so the next command is taken while it waits;
// the sequencer holds at its last step only while that register is full and not being read.
module lru_order_list (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [lol_pkg::IN_DATA_W-1:0]  i_s_tdata,  // command, entry_index
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [lol_pkg::OUT_DATA_W-1:0] o_m_tdata   // status, popped_index
);
    import lol_pkg::*;

    t_cmd     w_cmd;
    t_result  w_res;
    logic     w_idle;
    logic     w_res_ready;
    t_ram_req w_newer_req, w_older_req;
    t_link    w_newer_rdata, w_older_rdata;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    t_idx              r_out_popped;

    assign w_cmd.command     = i_s_tdata[CMD_W-1:0];
    assign w_cmd.entry_index = i_s_tdata[CMD_W+IDX_W-1:CMD_W];
    assign o_s_tready        = w_idle;
    assign w_res_ready       = !r_out_valid || i_m_tready;

    lol_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_s_tvalid),
        .i_cmd         (w_cmd),
        .o_idle        (w_idle),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res),
        .o_newer_req   (w_newer_req),
        .i_newer_rdata (w_newer_rdata),
        .o_older_req   (w_older_req),
        .i_older_rdata (w_older_rdata)
    );

    lol_link_ram u_newer_ram (
        .i_clk   (i_clk),
        .i_req   (w_newer_req),
        .o_rdata (w_newer_rdata)
    );

    lol_link_ram u_older_ram (
        .i_clk   (i_clk),
        .i_req   (w_older_req),
        .o_rdata (w_older_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_out_status <= w_res.status;
            r_out_popped <= w_res.popped_index;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - STAT_W - IDX_W){1'b0}}, r_out_popped, r_out_status};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over one that was not yet transferred");

endmodule

>>> tb/tb_lru_order_list.sv
// Self-checking testbench for the LRU order list: directed and random command streams.
module tb_lru_order_list;
    import lol_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_idx              popped;
    } answer_t;

    // Tracks the recency list alongside the block and holds the answers still owed.
    class recency_scoreboard;
        t_link   head_newest;
        t_link   head_oldest;
        t_link   newer_of [NUM_ENTRIES];
        t_link   older_of [NUM_ENTRIES];
        bit      listed   [NUM_ENTRIES];
        answer_t answers_due[$];
        int      mismatches;
        int      results_seen;

        function new();
            head_newest  = '0;
            head_oldest  = '0;
            mismatches   = 0;
            results_seen = 0;
            for (int k = 0; k < NUM_ENTRIES; k++) begin
                newer_of[k] = '0;
                older_of[k] = '0;
                listed[k]   = 1'b0;
            end
        endfunction

        function bit link_live(t_link p);
            return p.valid && (int'(p.slot) < NUM_ENTRIES);
        endfunction

        function void unlink(t_slot e);
            t_link n;
            t_link o;
            n = newer_of[e];
            o = older_of[e];
            if (link_live(n)) older_of[n.slot] = o;
            else head_newest = o;
            if (link_live(o)) newer_of[o.slot] = n;
            else head_oldest = n;
            newer_of[e] = '0;
            older_of[e] = '0;
            listed[e]   = 1'b0;
        endfunction

        function void link_newest(t_slot e);
            older_of[e] = head_newest;
            newer_of[e] = '0;
            if (link_live(head_newest)) newer_of[head_newest.slot] = '{valid: 1'b1, slot: e};
            else head_oldest = '{valid: 1'b1, slot: e};
            head_newest = '{valid: 1'b1, slot: e};
            listed[e]   = 1'b1;
        endfunction

        // Called for every accepted command transfer.
        function void apply_command(logic [CMD_W-1:0] cmd, t_idx idx);
            answer_t a;
            t_slot   e;
            t_slot   victim;
            t_link   self;
            a.status = ST_OK;
            a.popped = '0;
            e        = t_slot'(idx);
            self     = '{valid: 1'b1, slot: e};
            if (cmd == CMD_POP) begin
                if (!link_live(head_oldest)) begin
                    a.status = ST_EMPTY;
                end else begin
                    victim   = head_oldest.slot;
                    a.popped = t_idx'(victim);
                    unlink(victim);
                end
            end else if (int'(idx) >= NUM_ENTRIES) begin
                a.status = ST_NOT_LISTED;
            end else if (cmd == CMD_ADD) begin
                if (listed[e]) a.status = ST_LISTED;
                else link_newest(e);
            end else if (cmd == CMD_BUMP) begin
                if (!listed[e]) begin
                    a.status = ST_NOT_LISTED;
                end else if (head_newest != self) begin
                    unlink(e);
                    link_newest(e);
                end
            end else begin
                if (!listed[e]) a.status = ST_NOT_LISTED;
                else unlink(e);
            end
            answers_due.push_back(a);
        endfunction

        task report(string msg);
            $display("[%0t] result %0d: %s", $time, results_seen, msg);
            mismatches++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] d);
            answer_t want;
            if (answers_due.size() == 0) begin
                report("result with no command outstanding");
            end else begin
                want = answers_due.pop_front();
                if (d[STAT_W-1:0] !== want.status)
                    report($sformatf("status %0d, expected %0d", d[STAT_W-1:0], want.status));
                if (d[STAT_W +: IDX_W] !== want.popped)
                    report($sformatf("popped_index %0d, expected %0d",
                                     d[STAT_W +: IDX_W], want.popped));
                if (d[OUT_DATA_W-1:STAT_W+IDX_W] !== '0)
                    report($sformatf("fill bits not zero: %h", d));
            end
            results_seen++;
        endtask

        function t_idx pick_listed();
            int start;
            int s;
            start = $urandom_range(0, NUM_ENTRIES - 1);
            for (int k = 0; k < NUM_ENTRIES; k++) begin
                s = (start + k) % NUM_ENTRIES;
                if (listed[s]) return t_idx'(s);
            end
            return t_idx'(start);
        endfunction

        function bit any_listed();
            return link_live(head_oldest);
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    recency_scoreboard sb;
    bit                no_idle = 1'b0;

    lru_order_list u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Entered and left at a falling edge; returns once the transfer has happened.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input t_idx idx);
        int gap;
        gap = (no_idle || $urandom_range(0, 99) < 50) ? 0 : idle_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_DATA_W - CMD_W - IDX_W){1'b0}}, idx, cmd};
        do @(posedge i_clk); while (!o_s_tready);
        sb.apply_command(cmd, idx);
        @(negedge i_clk);
    endtask

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                hold--;
            end else if (no_idle || $urandom_range(0, 99) < 70) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                hold = idle_len() - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int               r;
        int               w_add;
        int               w_bump;
        int               w_pop;
        logic [CMD_W-1:0] cmd;
        t_idx             idx;
        t_idx             win_base;
        t_idx             win_mask;

        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty list, error cases, head and tail moves.
        send_cmd(CMD_POP,    8'hFF);
        send_cmd(CMD_REMOVE, 8'h00);
        send_cmd(CMD_BUMP,   8'hFF);
        send_cmd(CMD_ADD,    8'h00);
        send_cmd(CMD_ADD,    8'hFF);
        send_cmd(CMD_ADD,    8'h00);
        send_cmd(CMD_BUMP,   8'hFF);
        send_cmd(CMD_BUMP,   8'h00);
        send_cmd(CMD_ADD,    8'hAA);
        send_cmd(CMD_ADD,    8'h55);
        send_cmd(CMD_REMOVE, 8'h00);
        send_cmd(CMD_BUMP,   8'hAA);
        send_cmd(CMD_POP,    8'h00);
        send_cmd(CMD_POP,    8'hAA);
        send_cmd(CMD_POP,    8'h55);
        send_cmd(CMD_POP,    8'hFF);
        send_cmd(CMD_ADD,    8'h01);
        send_cmd(CMD_REMOVE, 8'h01);
        send_cmd(CMD_POP,    8'h00);
        send_cmd(CMD_ADD,    8'h02);
        send_cmd(CMD_ADD,    8'h03);
        send_cmd(CMD_REMOVE, 8'h03);
        send_cmd(CMD_REMOVE, 8'h02);
        send_cmd(CMD_REMOVE, 8'h02);

        // Random phases alternate between filling, churning and draining the list,
        // over either the whole slot range or a narrow window that forces collisions.
        for (int phase = 0; phase < 10; phase++) begin
            no_idle  = (phase % 4 == 3);
            win_mask = (phase % 3 == 1) ? 8'h0F : 8'hFF;
            win_base = t_idx'($urandom_range(0, 255));
            case (phase % 3)
                0: begin
                    w_add = 60; w_bump = 80; w_pop = 90;
                end
                1: begin
                    w_add = 35; w_bump = 60; w_pop = 80;
                end
                default: begin
                    w_add = 20; w_bump = 40; w_pop = 75;
                end
            endcase
            for (int n = 0; n < 195; n++) begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 15) begin
                    cmd = CMD_W'($urandom_range(0, 3));
                    idx = t_idx'($urandom_range(0, 255));
                end else if (r < w_add) begin
                    cmd = CMD_ADD;
                    idx = win_base ^ (t_idx'($urandom_range(0, 255)) & win_mask);
                end else if (r < w_pop && r >= w_bump) begin
                    cmd = CMD_POP;
                    idx = t_idx'($urandom_range(0, 255));
                end else begin
                    cmd = (r < w_bump) ? CMD_BUMP : CMD_REMOVE;
                    idx = sb.any_listed() ? sb.pick_listed() : t_idx'($urandom_range(0, 255));
                end
                send_cmd(cmd, idx);
            end
        end
        no_idle = 1'b0;
        i_s_tvalid <= 1'b0;

        while (sb.answers_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> lru_order_list.f
design/lol_pkg.sv
design/lol_link_ram.sv
design/lol_ctrl.sv
design/lru_order_list.sv
tb/tb_lru_order_list.sv
